@@ rtl/dcpe_pkg.sv @@
package dcpe_pkg;

   // Fixed field widths of the request, response and control register
   localparam int SAMPLE_W = 12;
   localparam int CFG_W = 10;
   localparam int COUNT_W = 11;
   localparam int AVG_W = 12;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 2;

   // Channel length after reset
   localparam logic [CFG_W-1:0] CHAN_LEN_RESET = 10'd200;

   // Extreme slots, in publication order
   localparam int IDX_MAX_A = 0;
   localparam int IDX_MIN_A = 1;
   localparam int IDX_MAX_B = 2;
   localparam int IDX_MIN_B = 3;
   localparam int NUM_EXT = 4;

   // Mux select codes
   localparam logic CHAN_A = 1'b0;
   localparam logic CHAN_B = 1'b1;

   typedef logic [AVG_W-1:0] avg_type;

   // One response as handed from the core to the output stage
   typedef struct packed {
      logic averages_updated;
      logic next_channel;
      avg_type [NUM_EXT-1:0] avgs;
   } result_type;

endpackage

@@ rtl/dcpe_core.sv @@
module dcpe_core import dcpe_pkg::*; #(
   parameter int AVG_LOG2 = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [CFG_W-1:0]    chan_len,
   output result_type          result
);

   localparam int SUM_W = SAMPLE_BITS + AVG_LOG2;
   localparam int WIN_W = AVG_LOG2 + 1;
   localparam logic [WIN_W-1:0] WIN_LAST = WIN_W'((1 << AVG_LOG2) - 1);
   localparam logic [SAMPLE_BITS-1:0] LOW_RESET = '1;

   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [WIN_W-1:0]       window_ff, window_in;
   logic [SAMPLE_BITS-1:0] high_ff [2];
   logic [SAMPLE_BITS-1:0] high_in [2];
   logic [SAMPLE_BITS-1:0] low_ff [2];
   logic [SAMPLE_BITS-1:0] low_in [2];
   logic [SUM_W-1:0]       sums_ff [NUM_EXT];
   logic [SUM_W-1:0]       sums_in [NUM_EXT];
   avg_type [NUM_EXT-1:0]  avg_ff;
   avg_type [NUM_EXT-1:0]  avg_in;
   result_type             result_ff, result_in;

   logic [SAMPLE_BITS-1:0] smp;
   logic [CFG_W-1:0]       n;
   logic [COUNT_W-1:0]     n_ext, two_n, count_inc;
   logic                   chan, close, publish;
   logic [SAMPLE_BITS-1:0] high_upd [2];
   logic [SAMPLE_BITS-1:0] low_upd [2];
   logic [SUM_W-1:0]       ext [NUM_EXT];
   logic [SUM_W-1:0]       total [NUM_EXT];

   // Decode length, channel and period end
   assign smp = SAMPLE_BITS'(sample);
   assign n = (chan_len == '0) ? CFG_W'(1) : chan_len;
   assign n_ext = {1'b0, n};
   assign two_n = {n, 1'b0};
   assign chan = (count_ff < n_ext) ? CHAN_A : CHAN_B;
   assign count_inc = count_ff + COUNT_W'(1);
   assign close = (count_inc >= two_n);
   assign publish = close && (window_ff == WIN_LAST);
   assign count_in = close ? '0 : count_inc;
   assign window_in = publish ? '0 : (close ? window_ff + WIN_W'(1) : window_ff);

   // Update the tracker of the selected channel
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         high_upd[c] = high_ff[c];
         low_upd[c] = low_ff[c];
         if (1'(c) == chan) begin
            if (smp > high_ff[c]) begin
               high_upd[c] = smp;
            end
            if (smp < low_ff[c]) begin
               low_upd[c] = smp;
            end
         end
         high_in[c] = close ? '0 : high_upd[c];
         low_in[c] = close ? LOW_RESET : low_upd[c];
      end
   end

   // Accumulate extremes at period end, publish by shift at block end
   always_comb begin
      ext[IDX_MAX_A] = SUM_W'(high_upd[0]);
      ext[IDX_MIN_A] = SUM_W'(low_upd[0]);
      ext[IDX_MAX_B] = SUM_W'(high_upd[1]);
      ext[IDX_MIN_B] = SUM_W'(low_upd[1]);
      for (int i = 0; i < NUM_EXT; i++) begin
         total[i] = sums_ff[i] + ext[i];
         sums_in[i] = publish ? '0 : (close ? total[i] : sums_ff[i]);
         avg_in[i] = publish ? AVG_W'(total[i] >> AVG_LOG2) : avg_ff[i];
      end
   end

   // Build the response
   always_comb begin
      result_in.averages_updated = publish;
      result_in.next_channel = (count_in < n_ext) ? CHAN_A : CHAN_B;
      for (int i = 0; i < NUM_EXT; i++) begin
         result_in.avgs[i] = avg_in[i];
      end
   end

   // Hold state between requests, advance on each step
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         window_ff <= '0;
         for (int c = 0; c < 2; c++) begin
            high_ff[c] <= '0;
            low_ff[c] <= LOW_RESET;
         end
         for (int i = 0; i < NUM_EXT; i++) begin
            sums_ff[i] <= '0;
            avg_ff[i] <= '0;
         end
      end else if (step) begin
         count_ff <= count_in;
         window_ff <= window_in;
         high_ff <= high_in;
         low_ff <= low_in;
         sums_ff <= sums_in;
         avg_ff <= avg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

   // Block counter stays within one averaging block
   a_window_range: assert property (@(posedge clock) disable iff (reset)
      window_ff <= WIN_LAST)
      else $error("window counter beyond block length");

   // A publication ends a period, so the mux returns to channel A
   a_publish_chan: assert property (@(posedge clock) disable iff (reset)
      step && publish |=> !result.next_channel)
      else $error("publication without return to channel A");

   // Published averages move only on a publication
   a_avg_hold: assert property (@(posedge clock) disable iff (reset)
      step && !publish |=> (avg_ff == $past(avg_ff)))
      else $error("averages changed outside a publication");

   // Channel A tracker holds at least one sample once a period is under way
   a_tracker_a: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 |-> high_ff[0] >= low_ff[0])
      else $error("channel A tracker empty mid-period");

endmodule

@@ rtl/dual_channel_peak_envelope_averager_top.sv @@
// Channel   Direction  Ports                          Content
// req       in         req_tvalid/tready/tdata        one converter sample
// rsp       out        rsp_tvalid/tready/tdata/tuser  mux select, update flag, averages
// csr       in         csr_valid/ready/wdata          samples per channel
//
// One request per cycle sustained while the response side does not stall.
// Input register, then one update of trackers, accumulators and counters into
// the response register. Reset is synchronous; channel length returns to 200.
// A stalled response holds the input register, which then stalls the request side.
module dual_channel_peak_envelope_averager_top import dcpe_pkg::*; #(
   parameter int AVG_LOG2 = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [11:0] sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [11:0] avg_max_a, [23:12] avg_min_a, [35:24] avg_max_b, [47:36] avg_min_b
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,  // [0] next_channel, [1] averages_updated
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_W-1:0]       csr_wdata
);

   logic [CFG_W-1:0]    len_ff;
   logic                req_valid_ff, req_valid_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                advance, step;
   result_type          result;

   // Channel length register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= CHAN_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         len_ff <= csr_wdata;
      end
   end

   // Pipeline flow: advance when the response slot is free or taken
   assign advance = !rsp_valid_ff || rsp_tready;
   assign step = req_valid_ff && advance;
   assign req_tready = !req_valid_ff || advance;
   assign req_valid_in = req_tready ? req_tvalid : req_valid_ff;
   assign rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request sample
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= req_tdata[SAMPLE_W-1:0];
      end
   end

   dcpe_core #(
      .AVG_LOG2    (AVG_LOG2),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .sample   (sample_ff),
      .chan_len (len_ff),
      .result   (result)
   );

   // Drive the response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = result.avgs;
   assign rsp_tuser = {result.averages_updated, result.next_channel};

endmodule
